/* rtl/core/hdb_pkg.sv */
// Shared constants for the hop deadline budget block.
package hdb_pkg;

   // default widths for internal time values and hop counts
   localparam int TIME_WIDTH_DEF = 48;
   localparam int HOP_WIDTH_DEF  = 8;

   // channel field widths
   localparam int PKT_BITS_W = 19;
   localparam int HOPS_W     = 8;
   localparam int UTIME_W    = 47;
   localparam int STIME_W    = 48;
   localparam int BIT_TIME_W = 32;

   // Ethernet framing: minimum payload and header in bits
   localparam int HEADER_BITS      = 208;
   localparam int PAYLOAD_MIN_BITS = 368;
   localparam int FRAME_BITS_W     = 20;

   // bit time is in 1/256 ps
   localparam int Q8_FRAC     = 8;
   localparam int WIRE_PROD_W = FRAME_BITS_W + BIT_TIME_W;
   localparam int WIRE_RAW_W  = WIRE_PROD_W - Q8_FRAC;

   // quotient bits resolved per divider stage
   localparam int DIV_STEP = 8;

   // bound lanes
   localparam int NUM_BOUNDS = 2;
   localparam int LANE_MIN   = 0;
   localparam int LANE_MAX   = 1;

endpackage

/* rtl/core/hdb_req_if.sv */
// Request channel: one packet descriptor per beat.
interface hdb_req_if;
   logic                              valid;
   logic                              ready;
   logic [hdb_pkg::PKT_BITS_W-1:0]    packet_bits;
   logic [hdb_pkg::HOPS_W-1:0]        from_hops;
   logic [hdb_pkg::HOPS_W-1:0]        to_hops;
   logic [hdb_pkg::UTIME_W-1:0]       from_base_delay;
   logic [hdb_pkg::UTIME_W-1:0]       to_base_delay;
   logic [hdb_pkg::UTIME_W-1:0]       link_delay;
   logic [hdb_pkg::UTIME_W-1:0]       accum_delay_in;
   logic [hdb_pkg::UTIME_W-1:0]       bound_min;
   logic [hdb_pkg::UTIME_W-1:0]       bound_max;
   logic                              from_network;
   logic [hdb_pkg::UTIME_W-1:0]       receive_time;

   modport source (
      output valid, packet_bits, from_hops, to_hops, from_base_delay, to_base_delay,
             link_delay, accum_delay_in, bound_min, bound_max, from_network, receive_time,
      input  ready
   );

   modport sink (
      input  valid, packet_bits, from_hops, to_hops, from_base_delay, to_base_delay,
             link_delay, accum_delay_in, bound_min, bound_max, from_network, receive_time,
      output ready
   );
endinterface

/* rtl/core/hdb_rsp_if.sv */
// Response channel: path delays, budgets and send times per beat.
interface hdb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [hdb_pkg::UTIME_W-1:0]         from_delay;
   logic [hdb_pkg::UTIME_W-1:0]         to_delay;
   logic [hdb_pkg::UTIME_W-1:0]         accum_delay_out;
   logic signed [hdb_pkg::STIME_W-1:0]  budget_min;
   logic signed [hdb_pkg::STIME_W-1:0]  budget_max;
   logic signed [hdb_pkg::STIME_W-1:0]  send_min;
   logic signed [hdb_pkg::STIME_W-1:0]  send_max;
   logic                                expired;

   modport source (
      output valid, from_delay, to_delay, accum_delay_out, budget_min, budget_max,
             send_min, send_max, expired,
      input  ready
   );

   modport sink (
      input  valid, from_delay, to_delay, accum_delay_out, budget_min, budget_max,
             send_min, send_max, expired,
      output ready
   );
endinterface

/* rtl/core/hop_deadline_budget.sv */
// Per-hop delay budget top level.
//
// req_chan carries one packet descriptor per beat (length, hop counts, table
// delays, link delay, accumulated delay, bounds, receive time); rsp_chan
// returns path delays, the updated accumulated delay, signed per-hop budgets
// for both bounds, the send times and the expiry flag. csr_we / csr_wdata
// write the link bit time in ps/256.
//
// Throughput is one beat per cycle while rsp_chan is not stalled. An accepted
// request reaches its response through six front stages, one divider stage
// per 8 quotient bits of the per-hop split, and two back stages, the last
// being the output register.
//
// Reset clears all stage valid bits and the bit time register; the block
// accepts requests in the first cycle after reset. When rsp_chan stalls the
// response holds in the output register, earlier stages keep filling their
// empty slots, and req_chan.ready drops only once every stage is occupied.
module hop_deadline_budget #(
   parameter int TIME_WIDTH = hdb_pkg::TIME_WIDTH_DEF,
   parameter int HOP_WIDTH  = hdb_pkg::HOP_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [hdb_pkg::BIT_TIME_W-1:0] csr_wdata,
   hdb_req_if.sink                        req_chan,
   hdb_rsp_if.source                      rsp_chan
);

   localparam int NB     = hdb_pkg::NUM_BOUNDS;
   localparam int SIDE_W = 4 * (TIME_WIDTH - 1) + NB;

   logic [hdb_pkg::BIT_TIME_W-1:0] bit_time_ff, bit_time_in;

   logic                             fr_valid, fr_ready;
   logic [NB-1:0][TIME_WIDTH-1:0]    fr_dividend;
   logic [HOP_WIDTH-1:0]             fr_divisor;
   logic [SIDE_W-1:0]                fr_side;

   logic                             dv_valid, dv_ready;
   logic [NB-1:0][TIME_WIDTH-1:0]    dv_quot;
   logic [SIDE_W-1:0]                dv_side;

   assign bit_time_in = csr_we ? csr_wdata : bit_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_time_ff <= '0;
      end else begin
         bit_time_ff <= bit_time_in;
      end
   end

   hdb_front #(
      .TIME_WIDTH (TIME_WIDTH),
      .HOP_WIDTH  (HOP_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .bit_time     (bit_time_ff),
      .req_chan     (req_chan),
      .out_valid    (fr_valid),
      .out_ready    (fr_ready),
      .out_dividend (fr_dividend),
      .out_divisor  (fr_divisor),
      .out_side     (fr_side)
   );

   hdb_divider #(
      .TIME_WIDTH (TIME_WIDTH),
      .HOP_WIDTH  (HOP_WIDTH),
      .SIDE_W     (SIDE_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (fr_valid),
      .in_ready    (fr_ready),
      .in_dividend (fr_dividend),
      .in_divisor  (fr_divisor),
      .in_side     (fr_side),
      .out_valid   (dv_valid),
      .out_ready   (dv_ready),
      .out_quot    (dv_quot),
      .out_side    (dv_side)
   );

   hdb_back #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (dv_valid),
      .in_ready (dv_ready),
      .in_quot  (dv_quot),
      .in_side  (dv_side),
      .rsp_chan (rsp_chan)
   );

endmodule

/* rtl/core/hdb_front.sv */
// Front pipeline: wire time, path delays, remaining delay and divider operands.
module hdb_front #(
   parameter int TIME_WIDTH = hdb_pkg::TIME_WIDTH_DEF,
   parameter int HOP_WIDTH  = hdb_pkg::HOP_WIDTH_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic [hdb_pkg::BIT_TIME_W-1:0]                     bit_time,
   hdb_req_if.sink                                            req_chan,
   output logic                                               out_valid,
   input  logic                                               out_ready,
   output logic [hdb_pkg::NUM_BOUNDS-1:0][TIME_WIDTH-1:0]     out_dividend,
   output logic [HOP_WIDTH-1:0]                               out_divisor,
   output logic [4*(TIME_WIDTH-1)+hdb_pkg::NUM_BOUNDS-1:0]    out_side
);

   localparam int TW  = TIME_WIDTH;
   localparam int HW  = HOP_WIDTH;
   localparam int UW  = TW - 1;
   localparam int NB  = hdb_pkg::NUM_BOUNDS;
   localparam int NS  = 6;
   localparam int HP_W = HW + UW;
   localparam int FW  = hdb_pkg::FRAME_BITS_W;
   localparam int PW  = hdb_pkg::WIRE_PROD_W;
   localparam int RW  = hdb_pkg::WIRE_RAW_W;
   localparam int IN_EXT_W   = (hdb_pkg::UTIME_W > UW) ? hdb_pkg::UTIME_W : UW;
   localparam int WIRE_EXT_W = (RW > UW) ? RW : UW;
   localparam int HOP_USE_W  = (hdb_pkg::HOPS_W < HW) ? hdb_pkg::HOPS_W : HW;

   localparam logic [UW-1:0] TMAXU  = {UW{1'b1}};
   localparam logic [TW:0]   TMINS_X = {2'b11, {UW{1'b0}}};

   typedef struct packed {
      logic [UW-1:0] fd;
      logic [UW-1:0] td;
      logic [UW-1:0] acc;
      logic [UW-1:0] rcv;
      logic [NB-1:0] neg;
   } side_type;

   typedef struct packed {
      logic [PW-1:0] prod;
      logic [HW-1:0] fh;
      logic [HW-1:0] th;
      logic [UW-1:0] fbase;
      logic [UW-1:0] tbase;
      logic [UW-1:0] link;
      logic [UW-1:0] acc;
      logic [UW-1:0] bmin;
      logic [UW-1:0] bmax;
      logic [UW-1:0] rcv;
      logic          from_net;
   } s1_type;

   typedef struct packed {
      logic [UW-1:0] wire_ps;
      logic [HW-1:0] fh;
      logic [HW-1:0] th;
      logic [UW-1:0] fbase;
      logic [UW-1:0] tbase;
      logic [UW-1:0] acc;
      logic [UW-1:0] bmin;
      logic [UW-1:0] bmax;
      logic [UW-1:0] rcv;
      logic          from_net;
   } s2_type;

   typedef struct packed {
      logic [HP_W-1:0] fprod;
      logic [HP_W-1:0] tprod;
      logic [HW-1:0]   th;
      logic [UW-1:0]   fbase;
      logic [UW-1:0]   tbase;
      logic [UW-1:0]   acc;
      logic [UW-1:0]   bmin;
      logic [UW-1:0]   bmax;
      logic [UW-1:0]   rcv;
   } s3_type;

   typedef struct packed {
      logic [UW-1:0] fd;
      logic [UW-1:0] td;
      logic [UW-1:0] acc;
      logic [UW-1:0] bmin;
      logic [UW-1:0] bmax;
      logic [UW-1:0] rcv;
      logic [HW-1:0] th;
   } s4_type;

   typedef struct packed {
      logic [NB-1:0][TW-1:0] rem;
      logic [UW-1:0]         fd;
      logic [UW-1:0]         td;
      logic [UW-1:0]         acc;
      logic [UW-1:0]         rcv;
      logic [HW-1:0]         th;
   } s5_type;

   typedef struct packed {
      logic [NB-1:0][TW-1:0] dividend;
      logic [HW-1:0]         divisor;
      side_type              side;
   } s6_type;

   function automatic logic [UW-1:0] clamp_in(input logic [hdb_pkg::UTIME_W-1:0] x);
      logic [IN_EXT_W-1:0] xe;
      xe = IN_EXT_W'(x);
      if (xe > IN_EXT_W'(TMAXU)) begin
         return TMAXU;
      end
      return xe[UW-1:0];
   endfunction

   function automatic logic [UW-1:0] clamp_wire(input logic [RW-1:0] x);
      logic [WIRE_EXT_W-1:0] xe;
      xe = WIRE_EXT_W'(x);
      if (xe > WIRE_EXT_W'(TMAXU)) begin
         return TMAXU;
      end
      return xe[UW-1:0];
   endfunction

   function automatic logic [UW-1:0] add_sat(input logic [UW-1:0] a, input logic [UW-1:0] b);
      logic [UW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[UW] ? TMAXU : s[UW-1:0];
   endfunction

   function automatic logic [UW-1:0] hop_sat(input logic [HP_W-1:0] p);
      return (|p[HP_W-1:UW]) ? TMAXU : p[UW-1:0];
   endfunction

   // bound - to - acc, floored at the most negative time
   function automatic logic [TW-1:0] rem_sat(input logic [UW-1:0] bound,
                                             input logic [UW-1:0] to,
                                             input logic [UW-1:0] acc);
      logic [TW:0] r;
      r = {2'b00, bound} - {2'b00, to} - {2'b00, acc};
      if ($signed(r) < $signed(TMINS_X)) begin
         return TMINS_X[TW-1:0];
      end
      return r[TW-1:0];
   endfunction

   logic [NS-1:0] v_ff, v_in;
   logic [NS:0]   rdy;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;

   // a stage takes a new beat when it is empty or its successor moves
   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_in[0] = rdy[0] ? req_chan.valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = rdy[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   // stage 1: pad to frame size, multiply by bit time
   always_comb begin
      logic [FW-1:0] pb;
      logic [FW-1:0] frame;
      pb = FW'(req_chan.packet_bits);
      frame = ((pb < FW'(hdb_pkg::PAYLOAD_MIN_BITS)) ? FW'(hdb_pkg::PAYLOAD_MIN_BITS) : pb)
              + FW'(hdb_pkg::HEADER_BITS);
      s1_in.prod     = PW'(frame) * PW'(bit_time);
      s1_in.fh       = HW'(req_chan.from_hops[HOP_USE_W-1:0]);
      s1_in.th       = HW'(req_chan.to_hops[HOP_USE_W-1:0]);
      s1_in.fbase    = clamp_in(req_chan.from_base_delay);
      s1_in.tbase    = clamp_in(req_chan.to_base_delay);
      s1_in.link     = clamp_in(req_chan.link_delay);
      s1_in.acc      = clamp_in(req_chan.accum_delay_in);
      s1_in.bmin     = clamp_in(req_chan.bound_min);
      s1_in.bmax     = clamp_in(req_chan.bound_max);
      s1_in.rcv      = clamp_in(req_chan.receive_time);
      s1_in.from_net = req_chan.from_network;
   end

   // stage 2: round to whole ps, first half of the accumulated delay (link delay, from network only)
   always_comb begin
      logic [PW-1:0] rounded;
      rounded = s1_ff.prod + PW'(1 << (hdb_pkg::Q8_FRAC - 1));
      s2_in.wire_ps  = clamp_wire(rounded[PW-1:hdb_pkg::Q8_FRAC]);
      s2_in.fh       = s1_ff.fh;
      s2_in.th       = s1_ff.th;
      s2_in.fbase    = s1_ff.fbase;
      s2_in.tbase    = s1_ff.tbase;
      s2_in.acc      = s1_ff.from_net ? add_sat(s1_ff.acc, s1_ff.link) : s1_ff.acc;
      s2_in.bmin     = s1_ff.bmin;
      s2_in.bmax     = s1_ff.bmax;
      s2_in.rcv      = s1_ff.rcv;
      s2_in.from_net = s1_ff.from_net;
   end

   // stage 3: hops times wire time, add wire time to accumulated delay when from network
   always_comb begin
      s3_in.fprod = HP_W'(s2_ff.fh) * HP_W'(s2_ff.wire_ps);
      s3_in.tprod = HP_W'(s2_ff.th) * HP_W'(s2_ff.wire_ps);
      s3_in.th    = s2_ff.th;
      s3_in.fbase = s2_ff.fbase;
      s3_in.tbase = s2_ff.tbase;
      s3_in.acc   = s2_ff.from_net ? add_sat(s2_ff.acc, s2_ff.wire_ps) : s2_ff.acc;
      s3_in.bmin  = s2_ff.bmin;
      s3_in.bmax  = s2_ff.bmax;
      s3_in.rcv   = s2_ff.rcv;
   end

   // stage 4: path delays
   always_comb begin
      s4_in.fd   = add_sat(hop_sat(s3_ff.fprod), s3_ff.fbase);
      s4_in.td   = add_sat(hop_sat(s3_ff.tprod), s3_ff.tbase);
      s4_in.acc  = s3_ff.acc;
      s4_in.bmin = s3_ff.bmin;
      s4_in.bmax = s3_ff.bmax;
      s4_in.rcv  = s3_ff.rcv;
      s4_in.th   = s3_ff.th;
   end

   // stage 5: remaining delay per bound, zero when the bound is absent
   always_comb begin
      s5_in.rem[hdb_pkg::LANE_MIN] = (s4_ff.bmin == '0) ? '0 :
                                     rem_sat(s4_ff.bmin, s4_ff.td, s4_ff.acc);
      s5_in.rem[hdb_pkg::LANE_MAX] = (s4_ff.bmax == '0) ? '0 :
                                     rem_sat(s4_ff.bmax, s4_ff.td, s4_ff.acc);
      s5_in.fd  = s4_ff.fd;
      s5_in.td  = s4_ff.td;
      s5_in.acc = s4_ff.acc;
      s5_in.rcv = s4_ff.rcv;
      s5_in.th  = s4_ff.th;
   end

   // stage 6: magnitude plus half divisor; zero hops divides by one
   always_comb begin
      logic [HW-1:0] dvs;
      logic [TW-1:0] mag;
      dvs = (s5_ff.th == '0) ? HW'(1) : s5_ff.th;
      for (int l = 0; l < NB; l++) begin
         s6_in.side.neg[l] = s5_ff.rem[l][TW-1];
         mag = s5_ff.rem[l][TW-1] ? (TW'(0) - s5_ff.rem[l]) : s5_ff.rem[l];
         s6_in.dividend[l] = mag + TW'(dvs >> 1);
      end
      s6_in.divisor  = dvs;
      s6_in.side.fd  = s5_ff.fd;
      s6_in.side.td  = s5_ff.td;
      s6_in.side.acc = s5_ff.acc;
      s6_in.side.rcv = s5_ff.rcv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_ff <= s1_in;
      end
      if (rdy[1]) begin
         s2_ff <= s2_in;
      end
      if (rdy[2]) begin
         s3_ff <= s3_in;
      end
      if (rdy[3]) begin
         s4_ff <= s4_in;
      end
      if (rdy[4]) begin
         s5_ff <= s5_in;
      end
      if (rdy[5]) begin
         s6_ff <= s6_in;
      end
   end

   assign req_chan.ready = rdy[0];
   assign out_valid      = v_ff[NS-1];
   assign out_dividend   = s6_ff.dividend;
   assign out_divisor    = s6_ff.divisor;
   assign out_side       = s6_ff.side;

endmodule

/* rtl/core/hdb_divider.sv */
// Pipelined restoring divider for both bound lanes, sideband carried along.
module hdb_divider #(
   parameter int TIME_WIDTH = hdb_pkg::TIME_WIDTH_DEF,
   parameter int HOP_WIDTH  = hdb_pkg::HOP_WIDTH_DEF,
   parameter int SIDE_W     = 4 * (hdb_pkg::TIME_WIDTH_DEF - 1) + hdb_pkg::NUM_BOUNDS
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   output logic                                            in_ready,
   input  logic [hdb_pkg::NUM_BOUNDS-1:0][TIME_WIDTH-1:0]  in_dividend,
   input  logic [HOP_WIDTH-1:0]                            in_divisor,
   input  logic [SIDE_W-1:0]                               in_side,
   output logic                                            out_valid,
   input  logic                                            out_ready,
   output logic [hdb_pkg::NUM_BOUNDS-1:0][TIME_WIDTH-1:0]  out_quot,
   output logic [SIDE_W-1:0]                               out_side
);

   localparam int TW   = TIME_WIDTH;
   localparam int HW   = HOP_WIDTH;
   localparam int NB   = hdb_pkg::NUM_BOUNDS;
   localparam int STEP = hdb_pkg::DIV_STEP;
   localparam int DS   = (TW + STEP - 1) / STEP;
   localparam int QW   = DS * STEP;

   // word shifts dividend bits out at the top and quotient bits in at the bottom
   typedef struct packed {
      logic [NB-1:0][QW-1:0] word;
      logic [NB-1:0][HW-1:0] rem;
      logic [HW-1:0]         divisor;
      logic [SIDE_W-1:0]     side;
   } dstage_type;

   dstage_type    st_ff [DS];
   dstage_type    st_in [DS];
   logic [DS-1:0] v_ff, v_in;
   logic [DS:0]   rdy;

   always_comb begin
      rdy[DS] = out_ready;
      for (int k = DS - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_in[0] = rdy[0] ? in_valid : v_ff[0];
      for (int k = 1; k < DS; k++) begin
         v_in[k] = rdy[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_comb begin
      dstage_type    src;
      logic [HW:0]   trial;
      logic [HW:0]   diff;
      logic          qbit;
      for (int k = 0; k < DS; k++) begin
         if (k == 0) begin
            for (int l = 0; l < NB; l++) begin
               src.word[l] = QW'(in_dividend[l]);
               src.rem[l]  = '0;
            end
            src.divisor = in_divisor;
            src.side    = in_side;
         end else begin
            src = st_ff[k-1];
         end
         for (int l = 0; l < NB; l++) begin
            for (int j = 0; j < STEP; j++) begin
               trial = {src.rem[l], src.word[l][QW-1]};
               diff  = trial - {1'b0, src.divisor};
               if (trial >= {1'b0, src.divisor}) begin
                  src.rem[l] = diff[HW-1:0];
                  qbit       = 1'b1;
               end else begin
                  src.rem[l] = trial[HW-1:0];
                  qbit       = 1'b0;
               end
               src.word[l] = {src.word[l][QW-2:0], qbit};
            end
         end
         st_in[k] = src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DS; k++) begin
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NB; l++) begin
         out_quot[l] = st_ff[DS-1].word[l][TW-1:0];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[DS-1];
   assign out_side  = st_ff[DS-1].side;

endmodule

/* rtl/core/hdb_back.sv */
// Back pipeline: signed budgets, send times, expiry and the output register.
module hdb_back #(
   parameter int TIME_WIDTH = hdb_pkg::TIME_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   output logic                                            in_ready,
   input  logic [hdb_pkg::NUM_BOUNDS-1:0][TIME_WIDTH-1:0]  in_quot,
   input  logic [4*(TIME_WIDTH-1)+hdb_pkg::NUM_BOUNDS-1:0] in_side,
   hdb_rsp_if.source                                       rsp_chan
);

   localparam int TW = TIME_WIDTH;
   localparam int UW = TW - 1;
   localparam int NB = hdb_pkg::NUM_BOUNDS;
   localparam int NS = 2;
   localparam int OU = hdb_pkg::UTIME_W;
   localparam int OS = hdb_pkg::STIME_W;

   typedef struct packed {
      logic [UW-1:0] fd;
      logic [UW-1:0] td;
      logic [UW-1:0] acc;
      logic [UW-1:0] rcv;
      logic [NB-1:0] neg;
   } side_type;

   typedef struct packed {
      logic [NB-1:0][TW-1:0] budget;
      logic [UW-1:0]         fd;
      logic [UW-1:0]         td;
      logic [UW-1:0]         acc;
      logic [UW-1:0]         rcv;
   } b1_type;

   typedef struct packed {
      logic [OU-1:0] from_delay;
      logic [OU-1:0] to_delay;
      logic [OU-1:0] accum_delay_out;
      logic [OS-1:0] budget_min;
      logic [OS-1:0] budget_max;
      logic [OS-1:0] send_min;
      logic [OS-1:0] send_max;
      logic          expired;
   } b2_type;

   // receive time plus budget, clipped at the largest time
   function automatic logic [TW-1:0] add_time(input logic [TW-1:0] bud,
                                              input logic [UW-1:0] rcv);
      logic [TW:0] s;
      s = {bud[TW-1], bud} + {2'b00, rcv};
      if (!s[TW] && s[TW-1]) begin
         return {1'b0, {UW{1'b1}}};
      end
      return s[TW-1:0];
   endfunction

   side_type    side;
   b1_type      b1_ff, b1_in;
   b2_type      b2_ff, b2_in;
   logic [NS-1:0] v_ff, v_in;
   logic [NS:0]   rdy;

   assign side = in_side;

   always_comb begin
      rdy[NS] = rsp_chan.ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_in[0] = rdy[0] ? in_valid : v_ff[0];
      v_in[1] = rdy[1] ? v_ff[0] : v_ff[1];
   end

   // restore the sign of the rounded quotient
   always_comb begin
      for (int l = 0; l < NB; l++) begin
         b1_in.budget[l] = side.neg[l] ? (TW'(0) - in_quot[l]) : in_quot[l];
      end
      b1_in.fd  = side.fd;
      b1_in.td  = side.td;
      b1_in.acc = side.acc;
      b1_in.rcv = side.rcv;
   end

   // send before receive happens exactly when the max budget is negative
   always_comb begin
      logic [TW-1:0] smin;
      logic [TW-1:0] smax;
      smin = add_time(b1_ff.budget[hdb_pkg::LANE_MIN], b1_ff.rcv);
      smax = add_time(b1_ff.budget[hdb_pkg::LANE_MAX], b1_ff.rcv);
      b2_in.from_delay      = OU'(b1_ff.fd);
      b2_in.to_delay        = OU'(b1_ff.td);
      b2_in.accum_delay_out = OU'(b1_ff.acc);
      b2_in.budget_min      = OS'($signed(b1_ff.budget[hdb_pkg::LANE_MIN]));
      b2_in.budget_max      = OS'($signed(b1_ff.budget[hdb_pkg::LANE_MAX]));
      b2_in.send_min        = OS'($signed(smin));
      b2_in.send_max        = OS'($signed(smax));
      b2_in.expired         = b1_ff.budget[hdb_pkg::LANE_MAX][TW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         b1_ff <= b1_in;
      end
      if (rdy[1]) begin
         b2_ff <= b2_in;
      end
   end

   assign in_ready                 = rdy[0];
   assign rsp_chan.valid           = v_ff[NS-1];
   assign rsp_chan.from_delay      = b2_ff.from_delay;
   assign rsp_chan.to_delay        = b2_ff.to_delay;
   assign rsp_chan.accum_delay_out = b2_ff.accum_delay_out;
   assign rsp_chan.budget_min      = b2_ff.budget_min;
   assign rsp_chan.budget_max      = b2_ff.budget_max;
   assign rsp_chan.send_min        = b2_ff.send_min;
   assign rsp_chan.send_max        = b2_ff.send_max;
   assign rsp_chan.expired         = b2_ff.expired;

endmodule
